/* rtl/gsqr_pkg.sv */
// ----------------------------------------------------------------------------
// gsqr_pkg
// Types, codes and fixed-point helpers for the Gram-Schmidt least-squares block.
// ----------------------------------------------------------------------------
`default_nettype none

package gsqr_pkg;

   localparam int DATA_W = 32;
   localparam int ACC_W  = 64;
   localparam int CSR_W  = 6;

   localparam logic signed [DATA_W-1:0] DATA_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] DATA_MIN = 32'sh8000_0000;

   // result kinds
   localparam logic [1:0] KIND_R        = 2'd0;
   localparam logic [1:0] KIND_COEF     = 2'd1;
   localparam logic [1:0] KIND_RESIDUAL = 2'd2;
   localparam logic [1:0] KIND_SINGULAR = 2'd3;

   // configuration register indexes
   localparam logic CSR_ROW_COUNT = 1'b0;
   localparam logic CSR_COL_COUNT = 1'b1;

   typedef struct packed {
      logic                     is_response;
      logic [4:0]               row;
      logic [1:0]               col;
      logic signed [DATA_W-1:0] value;
      logic                     last;
   } req_type;

   typedef struct packed {
      logic [1:0]               kind;
      logic [4:0]               out_row;
      logic [1:0]               out_col;
      logic signed [DATA_W-1:0] out_value;
      logic                     out_last;
   } rsp_type;

   // Q32.32 to Q16.16: add half an lsb, floor, saturate
   function automatic logic signed [DATA_W-1:0] narrow_q(input logic signed [ACC_W-1:0] p);
      logic signed [ACC_W-1:0] t;
      logic signed [47:0]      q;
      t = p + 64'sd32768;
      q = t[63:16];
      if (p > 64'sh7FFF_FFFF_FFFF_7FFF) begin
         return DATA_MAX;
      end
      if (q > 48'sh0000_7FFF_FFFF) begin
         return DATA_MAX;
      end
      if (q < -48'sh0000_8000_0000) begin
         return DATA_MIN;
      end
      return q[DATA_W-1:0];
   endfunction

   // signed 64-bit add, saturating
   function automatic logic [ACC_W-1:0] add_sat(input logic [ACC_W-1:0] a,
                                                input logic [ACC_W-1:0] b);
      logic [ACC_W:0] s;
      s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
      if (s[ACC_W] != s[ACC_W-1]) begin
         return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end
      return s[ACC_W-1:0];
   endfunction

   // unsigned 64-bit add, saturating
   function automatic logic [ACC_W-1:0] addu_sat(input logic [ACC_W-1:0] a,
                                                 input logic [ACC_W-1:0] b);
      logic [ACC_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[ACC_W] ? {ACC_W{1'b1}} : s[ACC_W-1:0];
   endfunction

   // a - b on data words, saturating
   function automatic logic signed [DATA_W-1:0] sub_sat(input logic signed [DATA_W-1:0] a,
                                                        input logic signed [DATA_W-1:0] b);
      logic [DATA_W:0] d;
      d = {a[DATA_W-1], a} - {b[DATA_W-1], b};
      if (d[DATA_W] != d[DATA_W-1]) begin
         return d[DATA_W] ? DATA_MIN : DATA_MAX;
      end
      return d[DATA_W-1:0];
   endfunction

endpackage

`default_nettype wire

/* rtl/gsqr_ram.sv */
// ----------------------------------------------------------------------------
// gsqr_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gsqr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

/* rtl/gram_schmidt_qr_least_squares.sv */
// ----------------------------------------------------------------------------
// gram_schmidt_qr_least_squares
// Least-squares fit by modified Gram-Schmidt QR in saturating Q16.16.
// ----------------------------------------------------------------------------
// Load requests write one design-matrix or response element each and are
// taken one per clock while the block is idle. The request marked last is
// stored and then starts the factorisation; req_stall stays high until the
// final result has been loaded into the output register. Each column takes
// a norm pass over its n rows, a square root, a reciprocal, then a scaling
// pass, a pass for every dot product and one for every column update; each
// residual takes a pass over the p columns. Speed is bounded by the single
// read port per copy of the column memory: every pass streams one element
// per cycle through a registered read, one multiplier and an accumulator or
// a write-back, and drains before the next pass, so reads never meet pending
// writes. Results are R(j,k) for k >= j, then the Q'y entries as
// coefficient results, then one residual per row, the last flagged. A zero
// column norm gives a single singular-status result instead. The stores are
// not cleared at reset: every element inside the configured size must be
// loaded before the run starts.
`default_nettype none

module gram_schmidt_qr_least_squares
   import gsqr_pkg::*;
#(
   parameter int MAX_ROWS = 32,
   parameter int MAX_COLS = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   // load requests
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire req_type          req_data,
   // results
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rsp_type               rsp_data,
   // configuration writes
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic             csr_index,
   input  wire logic [CSR_W-1:0] csr_wdata
);

   localparam int RW  = $clog2(MAX_ROWS);
   localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int RNW = $clog2(MAX_ROWS + 1);
   localparam int CNW = $clog2(MAX_COLS + 1);
   localparam int IW  = (RNW > CNW) ? RNW : CNW;
   localparam int AW  = CW + RW;

   // sequencer states
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_NORM   = 4'd1;
   localparam logic [3:0] S_SQRT   = 4'd2;
   localparam logic [3:0] S_RECIP  = 4'd3;
   localparam logic [3:0] S_SCALE  = 4'd4;
   localparam logic [3:0] S_DOTR   = 4'd5;
   localparam logic [3:0] S_DOTC   = 4'd6;
   localparam logic [3:0] S_UPD    = 4'd7;
   localparam logic [3:0] S_TRI    = 4'd8;
   localparam logic [3:0] S_COEF   = 4'd9;
   localparam logic [3:0] S_RES    = 4'd10;
   localparam logic [3:0] S_RESOUT = 4'd11;
   localparam logic [3:0] S_SING   = 4'd12;

   // ---------------------------------------------------------------- state
   logic [3:0]       state_ff, state_in;
   logic [5:0]       row_count_ff, row_count_in;
   logic [2:0]       col_count_ff, col_count_in;
   logic [RNW-1:0]   n_ff, n_in;
   logic [CNW-1:0]   p_ff, p_in;
   logic [CNW-1:0]   j_ff, j_in;
   logic [CNW-1:0]   k_ff, k_in;
   logic [CNW-1:0]   ej_ff, ej_in;
   logic [CNW-1:0]   ek_ff, ek_in;
   logic [RNW-1:0]   row_ff, row_in;
   logic [IW-1:0]    idx_ff, idx_in;
   logic             issue_ff, issue_in;

   // streaming pipeline
   logic                     s1_vld_ff, s2_vld_ff, s3_vld_ff;
   logic [IW-1:0]            s1_idx_ff, s2_idx_ff, s3_idx_ff;
   logic signed [ACC_W-1:0]  prod_ff, prod_in;
   logic signed [DATA_W-1:0] s2_b_ff, s3_b_ff, s3_val_ff;
   logic [ACC_W-1:0]         acc_ff, acc_in;
   logic signed [DATA_W-1:0] y_ff, y_in;

   // square root and reciprocal
   logic [ACC_W-1:0]  sq_v_ff, sq_v_in;
   logic [ACC_W-1:0]  sq_res_ff, sq_res_in;
   logic [ACC_W-1:0]  sq_bit_ff, sq_bit_in;
   logic [6:0]        iter_ff, iter_in;
   logic [33:0]       rem_ff, rem_in;
   logic [32:0]       quo_ff, quo_in;
   logic signed [DATA_W-1:0] inv_ff, inv_in;

   // triangle and coefficient stores
   logic signed [DATA_W-1:0] tri_ff  [MAX_COLS][MAX_COLS];
   logic signed [DATA_W-1:0] coef_ff [MAX_COLS];
   logic                     tri_wr_en, coef_wr_en;
   logic [CW-1:0]            tri_wr_j, tri_wr_k, coef_wr_j;
   logic signed [DATA_W-1:0] tri_wr_data, coef_wr_data;
   logic [CW-1:0]            tri_rd_j, tri_rd_k, coef_rd_j;
   logic signed [DATA_W-1:0] tri_rd, coef_rd;

   // output register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   logic    rsp_load, out_free;

   // memories
   logic                     col_wr_en;
   logic [AW-1:0]            col_wr_addr, col_a_addr, col_b_addr;
   logic [DATA_W-1:0]        col_wr_data, col_a_q, col_b_q, rsp_mem_q;
   logic                     resp_wr_en;
   logic [RW-1:0]            resp_rd_addr;

   logic req_accept, csr_accept, stream_state, stream_done, start;
   logic [IW-1:0] stream_len;
   logic [RNW-1:0] n_clamp;
   logic [CNW-1:0] p_clamp;
   logic signed [DATA_W-1:0] op_x, op_y, col_a, col_b;
   logic [ACC_W-1:0] sq_try;
   logic [33:0]      rem_shift;
   logic             rem_ge;
   logic             load_ok, row_ok, col_ok;

   assign req_accept = req_valid && !req_stall;
   assign csr_accept = csr_valid && csr_ready;
   assign req_stall  = (state_ff != S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign col_a = $signed(col_a_q);
   assign col_b = $signed(col_b_q);

   // clamp the configured size to what the stores hold
   always_comb begin
      if (row_count_ff == 6'd0) begin
         n_clamp = RNW'(1);
      end else if (int'(row_count_ff) > MAX_ROWS) begin
         n_clamp = RNW'(MAX_ROWS);
      end else begin
         n_clamp = RNW'(row_count_ff);
      end
      if (col_count_ff == 3'd0) begin
         p_clamp = CNW'(1);
      end else if (int'(col_count_ff) > MAX_COLS) begin
         p_clamp = CNW'(MAX_COLS);
      end else begin
         p_clamp = CNW'(col_count_ff);
      end
   end

   // ------------------------------------------------------------- memories
   assign row_ok  = int'(req_data.row) < MAX_ROWS;
   assign col_ok  = int'(req_data.col) < MAX_COLS;
   assign load_ok = req_accept && row_ok;

   assign resp_wr_en = load_ok && req_data.is_response;

   always_comb begin
      col_wr_en   = 1'b0;
      col_wr_addr = {CW'(req_data.col), RW'(req_data.row)};
      col_wr_data = req_data.value;
      if (state_ff == S_IDLE) begin
         col_wr_en = load_ok && !req_data.is_response && col_ok;
      end else if (s3_vld_ff && state_ff == S_SCALE) begin
         col_wr_en   = 1'b1;
         col_wr_addr = {j_ff[CW-1:0], s3_idx_ff[RW-1:0]};
         col_wr_data = s3_val_ff;
      end else if (s3_vld_ff && state_ff == S_UPD) begin
         col_wr_en   = 1'b1;
         col_wr_addr = {k_ff[CW-1:0], s3_idx_ff[RW-1:0]};
         col_wr_data = sub_sat(s3_b_ff, s3_val_ff);
      end
   end

   always_comb begin
      if (state_ff == S_RES) begin
         col_a_addr   = {idx_ff[CW-1:0], row_ff[RW-1:0]};
         resp_rd_addr = row_ff[RW-1:0];
      end else begin
         col_a_addr   = {j_ff[CW-1:0], idx_ff[RW-1:0]};
         resp_rd_addr = idx_ff[RW-1:0];
      end
      col_b_addr = {k_ff[CW-1:0], idx_ff[RW-1:0]};
   end

   // two copies of the column store give two reads per cycle
   gsqr_ram #(.WIDTH(DATA_W), .DEPTH(2 ** AW)) u_col_a_ram (
      .clock   (clock),
      .wr_en   (col_wr_en),
      .wr_addr (col_wr_addr),
      .wr_data (col_wr_data),
      .rd_addr (col_a_addr),
      .rd_data (col_a_q)
   );

   gsqr_ram #(.WIDTH(DATA_W), .DEPTH(2 ** AW)) u_col_b_ram (
      .clock   (clock),
      .wr_en   (col_wr_en),
      .wr_addr (col_wr_addr),
      .wr_data (col_wr_data),
      .rd_addr (col_b_addr),
      .rd_data (col_b_q)
   );

   gsqr_ram #(.WIDTH(DATA_W), .DEPTH(2 ** RW)) u_resp_ram (
      .clock   (clock),
      .wr_en   (resp_wr_en),
      .wr_addr (RW'(req_data.row)),
      .wr_data (req_data.value),
      .rd_addr (resp_rd_addr),
      .rd_data (rsp_mem_q)
   );

   // ------------------------------------------------------ small stores
   assign tri_rd_j  = (state_ff == S_UPD) ? j_ff[CW-1:0] : ej_ff[CW-1:0];
   assign tri_rd_k  = (state_ff == S_UPD) ? k_ff[CW-1:0] : ek_ff[CW-1:0];
   assign tri_rd    = tri_ff[tri_rd_j][tri_rd_k];
   assign coef_rd_j = (state_ff == S_RES) ? s1_idx_ff[CW-1:0] : ej_ff[CW-1:0];
   assign coef_rd   = coef_ff[coef_rd_j];

   always_ff @(posedge clock) begin
      if (tri_wr_en) begin
         tri_ff[tri_wr_j][tri_wr_k] <= tri_wr_data;
      end
      if (coef_wr_en) begin
         coef_ff[coef_wr_j] <= coef_wr_data;
      end
   end

   // -------------------------------------------------- streaming datapath
   assign stream_state = (state_ff == S_NORM) || (state_ff == S_SCALE) ||
                         (state_ff == S_DOTR) || (state_ff == S_DOTC) ||
                         (state_ff == S_UPD)  || (state_ff == S_RES);
   assign stream_done  = stream_state && !issue_ff && !s1_vld_ff && !s2_vld_ff && !s3_vld_ff;
   assign stream_len   = (state_ff == S_RES) ? IW'(p_ff) : IW'(n_ff);

   // pick the multiplier operands for the current pass
   always_comb begin
      op_x = col_a;
      op_y = col_a;
      case (state_ff)
         S_NORM:  begin op_x = col_a;              op_y = col_a;   end
         S_SCALE: begin op_x = col_a;              op_y = inv_ff;  end
         S_DOTR:  begin op_x = col_a;              op_y = col_b;   end
         S_DOTC:  begin op_x = $signed(rsp_mem_q); op_y = col_a;   end
         S_UPD:   begin op_x = tri_rd;             op_y = col_a;   end
         S_RES:   begin op_x = col_a;              op_y = coef_rd; end
         default: begin op_x = col_a;              op_y = col_a;   end
      endcase
      prod_in = op_x * op_y;
   end

   assign y_in = (s1_vld_ff && state_ff == S_RES) ? $signed(rsp_mem_q) : y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= issue_ff;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
      end
      s1_idx_ff <= idx_ff;
      s2_idx_ff <= s1_idx_ff;
      s3_idx_ff <= s2_idx_ff;
      prod_ff   <= prod_in;
      s2_b_ff   <= col_b;
      s3_b_ff   <= s2_b_ff;
      s3_val_ff <= narrow_q(prod_ff);
      y_ff      <= y_in;
   end

   // --------------------------------------------- iteration step logic
   assign sq_try    = sq_res_ff + sq_bit_ff;
   assign rem_shift = {rem_ff[32:0], (iter_ff == 7'd31)};
   assign rem_ge    = rem_shift >= {2'b00, sq_res_ff[31:0]};

   // ---------------------------------------------------------- sequencer
   always_comb begin
      state_in     = state_ff;
      row_count_in = row_count_ff;
      col_count_in = col_count_ff;
      n_in         = n_ff;
      p_in         = p_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      ej_in        = ej_ff;
      ek_in        = ek_ff;
      row_in       = row_ff;
      idx_in       = idx_ff;
      issue_in     = issue_ff;
      acc_in       = acc_ff;
      sq_v_in      = sq_v_ff;
      sq_res_in    = sq_res_ff;
      sq_bit_in    = sq_bit_ff;
      iter_in      = iter_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      inv_in       = inv_ff;
      tri_wr_en    = 1'b0;
      tri_wr_j     = j_ff[CW-1:0];
      tri_wr_k     = k_ff[CW-1:0];
      tri_wr_data  = narrow_q($signed(acc_ff));
      coef_wr_en   = 1'b0;
      coef_wr_j    = j_ff[CW-1:0];
      coef_wr_data = narrow_q($signed(acc_ff));
      rsp_load     = 1'b0;
      rsp_data_in  = rsp_data_ff;
      start        = 1'b0;

      if (csr_accept) begin
         case (csr_index)
            CSR_ROW_COUNT: row_count_in = csr_wdata;
            CSR_COL_COUNT: col_count_in = csr_wdata[2:0];
            default:       row_count_in = row_count_ff;
         endcase
      end

      // advance the issue counter of a streaming pass
      if (issue_ff) begin
         idx_in = idx_ff + IW'(1);
         if (idx_ff + IW'(1) == stream_len) begin
            issue_in = 1'b0;
         end
      end

      // accumulate products leaving the multiplier
      if (s2_vld_ff) begin
         if (state_ff == S_NORM) begin
            acc_in = addu_sat(acc_ff, prod_ff);
         end else if (state_ff == S_DOTR || state_ff == S_DOTC || state_ff == S_RES) begin
            acc_in = add_sat(acc_ff, prod_ff);
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (req_accept && req_data.last) begin
               n_in     = n_clamp;
               p_in     = p_clamp;
               j_in     = '0;
               state_in = S_NORM;
               start    = 1'b1;
            end
         end
         S_NORM: begin
            if (stream_done) begin
               sq_v_in   = acc_ff;
               sq_res_in = '0;
               sq_bit_in = 64'h4000_0000_0000_0000;
               iter_in   = '0;
               state_in  = S_SQRT;
            end
         end
         S_SQRT: begin
            if (iter_ff < 7'd32) begin
               if (sq_v_ff >= sq_try) begin
                  sq_v_in   = sq_v_ff - sq_try;
                  sq_res_in = (sq_res_ff >> 1) + sq_bit_ff;
               end else begin
                  sq_res_in = sq_res_ff >> 1;
               end
               sq_bit_in = sq_bit_ff >> 2;
               iter_in   = iter_ff + 7'd1;
            end else begin
               // record the diagonal, then divide or stop on a dead column
               tri_wr_en   = 1'b1;
               tri_wr_k    = j_ff[CW-1:0];
               tri_wr_data = sq_res_ff[31] ? DATA_MAX : $signed(sq_res_ff[31:0]);
               if (sq_res_ff[31:0] == 32'd0) begin
                  state_in = S_SING;
               end else begin
                  rem_in   = '0;
                  quo_in   = '0;
                  iter_in  = '0;
                  state_in = S_RECIP;
               end
            end
         end
         S_RECIP: begin
            if (iter_ff < 7'd64) begin
               rem_in  = rem_ge ? rem_shift - {2'b00, sq_res_ff[31:0]} : rem_shift;
               quo_in  = {quo_ff[31:0], rem_ge};
               iter_in = iter_ff + 7'd1;
            end else begin
               inv_in   = (quo_ff[32:31] != 2'b00) ? DATA_MAX : $signed(quo_ff[31:0]);
               state_in = S_SCALE;
               start    = 1'b1;
            end
         end
         S_SCALE: begin
            if (stream_done) begin
               k_in     = j_ff + CNW'(1);
               state_in = (j_ff + CNW'(1) < p_ff) ? S_DOTR : S_DOTC;
               start    = 1'b1;
            end
         end
         S_DOTR: begin
            if (stream_done) begin
               tri_wr_en = 1'b1;
               start     = 1'b1;
               if (k_ff + CNW'(1) < p_ff) begin
                  k_in = k_ff + CNW'(1);
               end else begin
                  state_in = S_DOTC;
               end
            end
         end
         S_DOTC: begin
            if (stream_done) begin
               coef_wr_en = 1'b1;
               k_in       = j_ff + CNW'(1);
               if (j_ff + CNW'(1) < p_ff) begin
                  state_in = S_UPD;
                  start    = 1'b1;
               end else begin
                  state_in = S_TRI;
                  ej_in    = '0;
                  ek_in    = '0;
               end
            end
         end
         S_UPD: begin
            if (stream_done) begin
               if (k_ff + CNW'(1) < p_ff) begin
                  k_in  = k_ff + CNW'(1);
                  start = 1'b1;
               end else begin
                  // next column; the last one always ends in S_DOTC
                  j_in     = j_ff + CNW'(1);
                  state_in = S_NORM;
                  start    = 1'b1;
               end
            end
         end
         S_TRI: begin
            if (out_free) begin
               rsp_load    = 1'b1;
               rsp_data_in = '{kind: KIND_R, out_row: 5'(ej_ff), out_col: 2'(ek_ff),
                               out_value: tri_rd, out_last: 1'b0};
               if (ek_ff + CNW'(1) == p_ff) begin
                  if (ej_ff + CNW'(1) == p_ff) begin
                     ej_in    = '0;
                     state_in = S_COEF;
                  end else begin
                     ej_in = ej_ff + CNW'(1);
                     ek_in = ej_ff + CNW'(1);
                  end
               end else begin
                  ek_in = ek_ff + CNW'(1);
               end
            end
         end
         S_COEF: begin
            if (out_free) begin
               rsp_load    = 1'b1;
               rsp_data_in = '{kind: KIND_COEF, out_row: 5'(ej_ff), out_col: 2'd0,
                               out_value: coef_rd, out_last: 1'b0};
               if (ej_ff + CNW'(1) == p_ff) begin
                  row_in   = '0;
                  state_in = S_RES;
                  start    = 1'b1;
               end else begin
                  ej_in = ej_ff + CNW'(1);
               end
            end
         end
         S_RES: begin
            if (stream_done) begin
               state_in = S_RESOUT;
            end
         end
         S_RESOUT: begin
            if (out_free) begin
               rsp_load    = 1'b1;
               rsp_data_in = '{kind: KIND_RESIDUAL, out_row: 5'(row_ff), out_col: 2'd0,
                               out_value: sub_sat(y_ff, narrow_q($signed(acc_ff))),
                               out_last: (row_ff + RNW'(1) == n_ff)};
               if (row_ff + RNW'(1) == n_ff) begin
                  state_in = S_IDLE;
               end else begin
                  row_in   = row_ff + RNW'(1);
                  state_in = S_RES;
                  start    = 1'b1;
               end
            end
         end
         S_SING: begin
            if (out_free) begin
               rsp_load    = 1'b1;
               rsp_data_in = '{kind: KIND_SINGULAR, out_row: 5'd0, out_col: 2'(j_ff),
                               out_value: '0, out_last: 1'b1};
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // open a fresh streaming pass
      if (start) begin
         idx_in   = '0;
         issue_in = 1'b1;
         acc_in   = '0;
      end
   end

   // hold a result until it is taken; drop valid once it leaves
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         row_count_ff <= 6'd32;
         col_count_ff <= 3'd4;
         issue_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_count_ff <= row_count_in;
         col_count_ff <= col_count_in;
         issue_ff     <= issue_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff        <= n_in;
      p_ff        <= p_in;
      j_ff        <= j_in;
      k_ff        <= k_in;
      ej_ff       <= ej_in;
      ek_ff       <= ek_in;
      row_ff      <= row_in;
      idx_ff      <= idx_in;
      acc_ff      <= acc_in;
      sq_v_ff     <= sq_v_in;
      sq_res_ff   <= sq_res_in;
      sq_bit_ff   <= sq_bit_in;
      iter_ff     <= iter_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      inv_ff      <= inv_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire
